// ----- hdl/mhnt_pkg.sv -----
// ----------------------------------------------------------------------------
// mhnt_pkg
// Shared types, constants and encoder functions for the held note tracker.
// ----------------------------------------------------------------------------
package mhnt_pkg;

  localparam int CHANNELS   = 16;
  localparam int NOTES      = 128;
  localparam int GROUP_W    = 8;
  localparam int GROUPS     = NOTES / GROUP_W;

  localparam int STATUS_W   = 8;
  localparam int NOTE_W     = $clog2(NOTES);
  localparam int VEL_W      = 7;
  localparam int COUNT_W    = 12;
  localparam int CHAN_OUT_W = 5;
  localparam int CH_IDX_W   = $clog2(CHANNELS);
  localparam int GRP_IDX_W  = $clog2(GROUPS);
  localparam int OFF_W      = $clog2(GROUP_W);

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_FIND,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic find;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_hold;
  } dp_stat_t;

  function automatic logic [CH_IDX_W-1:0] lowest_channel(input logic [CHANNELS-1:0] v);
    logic [CH_IDX_W-1:0] idx;
    idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (v[i]) idx = CH_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [GRP_IDX_W-1:0] lowest_group(input logic [GROUPS-1:0] v);
    logic [GRP_IDX_W-1:0] idx;
    idx = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (v[i]) idx = GRP_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [GRP_IDX_W-1:0] highest_group(input logic [GROUPS-1:0] v);
    logic [GRP_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < GROUPS; i++) begin
      if (v[i]) idx = GRP_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [OFF_W-1:0] lowest_offset(input logic [GROUP_W-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (v[i]) idx = OFF_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [OFF_W-1:0] highest_offset(input logic [GROUP_W-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      if (v[i]) idx = OFF_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- hdl/mhnt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mhnt_ctrl
// Sequencer: accept, update the map, find the extremes, report.
// ----------------------------------------------------------------------------
module mhnt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mhnt_pkg::dp_stat_t  stat,
  output mhnt_pkg::ctrl_cmd_t cmd
);

  mhnt_pkg::state_t state_r;
  mhnt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhnt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhnt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mhnt_pkg::ST_UPDATE;
      end
      mhnt_pkg::ST_UPDATE: state_nxt = mhnt_pkg::ST_FIND;
      mhnt_pkg::ST_FIND:   state_nxt = mhnt_pkg::ST_REPORT;
      mhnt_pkg::ST_REPORT: begin
        if (!stat.out_hold) state_nxt = mhnt_pkg::ST_IDLE;
      end
      default: state_nxt = mhnt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      mhnt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      mhnt_pkg::ST_UPDATE: cmd.update = 1'b1;
      mhnt_pkg::ST_FIND:   cmd.find   = 1'b1;
      // The result register may still hold an earlier beat; wait until it drains.
      mhnt_pkg::ST_REPORT: cmd.report = !stat.out_hold;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hdl/mhnt_dp.sv -----
// ----------------------------------------------------------------------------
// mhnt_dp
// Note map memory, nonzero flags, held count, extreme search and result
// register.
// ----------------------------------------------------------------------------
module mhnt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mhnt_pkg::ctrl_cmd_t                 cmd,
  output mhnt_pkg::dp_stat_t                  stat,
  input  logic [mhnt_pkg::STATUS_W-1:0]       in_status_byte,
  input  logic [mhnt_pkg::NOTE_W-1:0]         in_note_number,
  input  logic [mhnt_pkg::VEL_W-1:0]          in_velocity,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mhnt_pkg::COUNT_W-1:0]        out_held_count,
  output logic                                out_any_held,
  output logic [mhnt_pkg::NOTE_W-1:0]         out_lowest_note,
  output logic [mhnt_pkg::CHAN_OUT_W-1:0]     out_lowest_channel,
  output logic [mhnt_pkg::NOTE_W-1:0]         out_highest_note,
  output logic [mhnt_pkg::CHAN_OUT_W-1:0]     out_highest_channel
);

  // One word per note, one bit per channel.
  logic [mhnt_pkg::CHANNELS-1:0] mem [mhnt_pkg::NOTES];

  logic [mhnt_pkg::STATUS_W-1:0]   status_r;
  logic [mhnt_pkg::NOTE_W-1:0]     note_r;
  logic [mhnt_pkg::VEL_W-1:0]      vel_r;
  logic [mhnt_pkg::CHANNELS-1:0]   rd_a_r;
  logic [mhnt_pkg::CHANNELS-1:0]   rd_b_r;
  logic [mhnt_pkg::NOTES-1:0]      nz_r;
  logic [mhnt_pkg::COUNT_W-1:0]    count_r;
  logic [mhnt_pkg::NOTE_W-1:0]     lo_note_r;
  logic [mhnt_pkg::NOTE_W-1:0]     hi_note_r;
  logic                            any_r;

  logic                            out_valid_r;
  logic [mhnt_pkg::COUNT_W-1:0]    out_count_r;
  logic                            out_any_r;
  logic [mhnt_pkg::NOTE_W-1:0]     out_lo_note_r;
  logic [mhnt_pkg::CHAN_OUT_W-1:0] out_lo_chan_r;
  logic [mhnt_pkg::NOTE_W-1:0]     out_hi_note_r;
  logic [mhnt_pkg::CHAN_OUT_W-1:0] out_hi_chan_r;

  logic [3:0]                      kind;
  logic [mhnt_pkg::CH_IDX_W-1:0]   chan;
  logic [mhnt_pkg::CHANNELS-1:0]   word;
  logic [mhnt_pkg::CHANNELS-1:0]   chan_bit;
  logic [mhnt_pkg::CHANNELS-1:0]   word_new;
  logic                            was_held;
  logic                            do_set;
  logic                            do_clr;
  logic                            wr_en;
  logic [mhnt_pkg::COUNT_W-1:0]    count_nxt;

  logic [mhnt_pkg::GROUPS-1:0]     grp_any;
  logic [mhnt_pkg::GRP_IDX_W-1:0]  lo_grp;
  logic [mhnt_pkg::GRP_IDX_W-1:0]  hi_grp;
  logic [mhnt_pkg::GROUP_W-1:0]    lo_slice;
  logic [mhnt_pkg::GROUP_W-1:0]    hi_slice;
  logic [mhnt_pkg::NOTE_W-1:0]     lo_note_nxt;
  logic [mhnt_pkg::NOTE_W-1:0]     hi_note_nxt;
  logic [mhnt_pkg::NOTE_W-1:0]     rd_addr_a;

  // Read-modify-write of one map word. A word whose flag is clear is all zero,
  // whether or not it was ever written.
  always_comb begin
    kind      = status_r[mhnt_pkg::STATUS_W-1 -: 4];
    chan      = status_r[mhnt_pkg::CH_IDX_W-1:0];
    word      = nz_r[note_r] ? rd_a_r : '0;
    chan_bit  = mhnt_pkg::CHANNELS'(1) << chan;
    was_held  = word[chan];
    do_set    = (kind == mhnt_pkg::KIND_NOTE_ON) && (vel_r != '0) && !was_held;
    do_clr    = ((kind == mhnt_pkg::KIND_NOTE_OFF) ||
                 ((kind == mhnt_pkg::KIND_NOTE_ON) && (vel_r == '0))) && was_held;
    word_new  = do_set ? (word | chan_bit) : (word & ~chan_bit);
    wr_en     = cmd.update && (do_set || do_clr);
    count_nxt = count_r;
    if (do_set) count_nxt = count_r + mhnt_pkg::COUNT_W'(1);
    else if (do_clr) count_nxt = count_r - mhnt_pkg::COUNT_W'(1);
  end

  // Two-level search: groups of notes first, then the note inside the group.
  always_comb begin
    for (int g = 0; g < mhnt_pkg::GROUPS; g++) begin
      grp_any[g] = |nz_r[g*mhnt_pkg::GROUP_W +: mhnt_pkg::GROUP_W];
    end
    lo_grp      = mhnt_pkg::lowest_group(grp_any);
    hi_grp      = mhnt_pkg::highest_group(grp_any);
    lo_slice    = nz_r[lo_grp*mhnt_pkg::GROUP_W +: mhnt_pkg::GROUP_W];
    hi_slice    = nz_r[hi_grp*mhnt_pkg::GROUP_W +: mhnt_pkg::GROUP_W];
    lo_note_nxt = {lo_grp, mhnt_pkg::lowest_offset(lo_slice)};
    hi_note_nxt = {hi_grp, mhnt_pkg::highest_offset(hi_slice)};
    rd_addr_a   = cmd.find ? lo_note_nxt : in_note_number;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[note_r] <= word_new;
    if (cmd.load || cmd.find) rd_a_r <= mem[rd_addr_a];
    if (cmd.find) rd_b_r <= mem[hi_note_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r    <= '0;
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
      if (wr_en) nz_r[note_r] <= |word_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= in_status_byte;
      note_r   <= in_note_number;
      vel_r    <= in_velocity;
    end
    if (cmd.find) begin
      lo_note_r <= lo_note_nxt;
      hi_note_r <= hi_note_nxt;
      any_r     <= |grp_any;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.report) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_count_r   <= count_r;
      out_any_r     <= count_r != '0;
      out_lo_note_r <= any_r ? lo_note_r : '0;
      out_hi_note_r <= any_r ? hi_note_r : '0;
      out_lo_chan_r <= any_r ? mhnt_pkg::CHAN_OUT_W'(mhnt_pkg::lowest_channel(rd_a_r)) +
                               mhnt_pkg::CHAN_OUT_W'(1) : '0;
      out_hi_chan_r <= any_r ? mhnt_pkg::CHAN_OUT_W'(mhnt_pkg::lowest_channel(rd_b_r)) +
                               mhnt_pkg::CHAN_OUT_W'(1) : '0;
    end
  end

  assign stat.out_hold       = out_valid_r && out_stall;
  assign out_valid           = out_valid_r;
  assign out_held_count      = out_count_r;
  assign out_any_held        = out_any_r;
  assign out_lowest_note     = out_lo_note_r;
  assign out_lowest_channel  = out_lo_chan_r;
  assign out_highest_note    = out_hi_note_r;
  assign out_highest_channel = out_hi_chan_r;

endmodule

// ----- hdl/midi_held_note_tracker.sv -----
// ----------------------------------------------------------------------------
// midi_held_note_tracker
// Tracks held notes per MIDI channel and reports count and note extremes.
// ----------------------------------------------------------------------------
//  channel  direction  handshake         payload
//  in_      input      in_valid/stall    status_byte, note_number, velocity
//  out_     output     out_valid/stall   held_count, any_held, lowest/highest
//                                        note and channel
//
// Each beat goes through accept with map read, map update, two-level
// search over the note flags with two map reads, then the result register.
// A new beat is accepted once the previous result is loaded into the output
// register, even while that result is stalled. The map is clear right after
// reset through per-note flags; there is no clearing pass.
// ----------------------------------------------------------------------------
module midi_held_note_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mhnt_pkg::STATUS_W-1:0]   in_status_byte,
  input  logic [mhnt_pkg::NOTE_W-1:0]     in_note_number,
  input  logic [mhnt_pkg::VEL_W-1:0]      in_velocity,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mhnt_pkg::COUNT_W-1:0]    out_held_count,
  output logic                            out_any_held,
  output logic [mhnt_pkg::NOTE_W-1:0]     out_lowest_note,
  output logic [mhnt_pkg::CHAN_OUT_W-1:0] out_lowest_channel,
  output logic [mhnt_pkg::NOTE_W-1:0]     out_highest_note,
  output logic [mhnt_pkg::CHAN_OUT_W-1:0] out_highest_channel
);

  mhnt_pkg::ctrl_cmd_t cmd;
  mhnt_pkg::dp_stat_t  stat;

  mhnt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mhnt_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_status_byte      (in_status_byte),
    .in_note_number      (in_note_number),
    .in_velocity         (in_velocity),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_held_count      (out_held_count),
    .out_any_held        (out_any_held),
    .out_lowest_note     (out_lowest_note),
    .out_lowest_channel  (out_lowest_channel),
    .out_highest_note    (out_highest_note),
    .out_highest_channel (out_highest_channel)
  );

endmodule

// ----- hdl/mhnt_checker.sv -----
// ----------------------------------------------------------------------------
// mhnt_checker
// Port-level checks for the held note tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mhnt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [mhnt_pkg::COUNT_W-1:0]    out_held_count,
  input logic                            out_any_held,
  input logic [mhnt_pkg::NOTE_W-1:0]     out_lowest_note,
  input logic [mhnt_pkg::CHAN_OUT_W-1:0] out_lowest_channel,
  input logic [mhnt_pkg::NOTE_W-1:0]     out_highest_note,
  input logic [mhnt_pkg::CHAN_OUT_W-1:0] out_highest_channel
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_held_count) &&
      $stable(out_lowest_note) && $stable(out_highest_note))
    else $error("stalled result changed");

  // The block works on one beat at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  a_any_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_any_held == (out_held_count != '0))
    else $error("any_held disagrees with held_count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_held |-> out_lowest_note == '0 && out_highest_note == '0 &&
      out_lowest_channel == '0 && out_highest_channel == '0)
    else $error("empty map reported a note");

  a_held_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_any_held |-> out_lowest_note <= out_highest_note &&
      out_lowest_channel != '0 && out_highest_channel != '0 &&
      out_lowest_channel <= mhnt_pkg::CHAN_OUT_W'(mhnt_pkg::CHANNELS) &&
      out_highest_channel <= mhnt_pkg::CHAN_OUT_W'(mhnt_pkg::CHANNELS))
    else $error("held note extremes out of order or range");

endmodule

bind midi_held_note_tracker mhnt_checker u_mhnt_checker (.*);

// ----- dv/midi_held_note_tracker_tb.sv -----
// ----------------------------------------------------------------------------
// midi_held_note_tracker_tb
// Self-checking bench for the held note tracker. A directed table covers
// reset, the note range ends, repeated presses and releases, channel ties and
// non-note statuses. Random phases then follow with changing sender gaps and
// receiver stalls, a long receiver hold-off, and drains between phases. Each
// result beat is checked against a typed row's expectation or the shadow map.
// ----------------------------------------------------------------------------
module midi_held_note_tracker_tb;

  typedef struct packed {
    logic [mhnt_pkg::COUNT_W-1:0]    count;
    logic                            any_held;
    logic [mhnt_pkg::NOTE_W-1:0]     low_note;
    logic [mhnt_pkg::CHAN_OUT_W-1:0] low_chan;
    logic [mhnt_pkg::NOTE_W-1:0]     high_note;
    logic [mhnt_pkg::CHAN_OUT_W-1:0] high_chan;
  } summary_t;

  typedef struct packed {
    logic [mhnt_pkg::STATUS_W-1:0] status;
    logic [mhnt_pkg::NOTE_W-1:0]   note;
    logic [mhnt_pkg::VEL_W-1:0]    vel;
    logic                          typed;
    summary_t                      want;
  } stim_row_t;

  localparam summary_t NOTHING = '0;
  localparam int DIRECTED_N = 23;
  localparam int PHASE_BEATS = 120;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_GUARD = 20000;

  // Rows with typed set carry an expectation read straight off the behavior;
  // the rest are checked against the shadow map.
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{8'hF0, 7'd0,   7'd0,   1'b1, NOTHING},
    '{8'h80, 7'd0,   7'd0,   1'b1, NOTHING},
    '{8'h90, 7'd0,   7'd127, 1'b1, '{12'd1, 1'b1, 7'd0, 5'd1, 7'd0,   5'd1}},
    '{8'h9F, 7'd127, 7'd1,   1'b1, '{12'd2, 1'b1, 7'd0, 5'd1, 7'd127, 5'd16}},
    '{8'h9F, 7'd127, 7'd85,  1'b1, '{12'd2, 1'b1, 7'd0, 5'd1, 7'd127, 5'd16}},
    '{8'h95, 7'd127, 7'd64,  1'b1, '{12'd3, 1'b1, 7'd0, 5'd1, 7'd127, 5'd6}},
    '{8'h93, 7'd0,   7'd34,  1'b1, '{12'd4, 1'b1, 7'd0, 5'd1, 7'd127, 5'd6}},
    '{8'h80, 7'd0,   7'd64,  1'b1, '{12'd3, 1'b1, 7'd0, 5'd4, 7'd127, 5'd6}},
    '{8'h80, 7'd0,   7'd64,  1'b1, '{12'd3, 1'b1, 7'd0, 5'd4, 7'd127, 5'd6}},
    '{8'h95, 7'd127, 7'd0,   1'b1, '{12'd2, 1'b1, 7'd0, 5'd4, 7'd127, 5'd16}},
    '{8'hA0, 7'd64,  7'd64,  1'b0, NOTHING},
    '{8'hB7, 7'd64,  7'd127, 1'b0, NOTHING},
    '{8'hC3, 7'd18,  7'd0,   1'b0, NOTHING},
    '{8'hD9, 7'd127, 7'd127, 1'b0, NOTHING},
    '{8'hE0, 7'd0,   7'd127, 1'b0, NOTHING},
    '{8'h00, 7'd85,  7'd42,  1'b0, NOTHING},
    '{8'hFF, 7'd42,  7'd85,  1'b0, NOTHING},
    '{8'h7F, 7'd127, 7'd127, 1'b0, NOTHING},
    '{8'h9A, 7'd64,  7'd42,  1'b0, NOTHING},
    '{8'h8F, 7'd127, 7'd127, 1'b0, NOTHING},
    '{8'h83, 7'd0,   7'd1,   1'b0, NOTHING},
    '{8'h9A, 7'd64,  7'd0,   1'b0, NOTHING},
    '{8'h98, 7'd0,   7'd0,   1'b1, NOTHING}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [mhnt_pkg::STATUS_W-1:0]   in_status_byte = '0;
  logic [mhnt_pkg::NOTE_W-1:0]     in_note_number = '0;
  logic [mhnt_pkg::VEL_W-1:0]      in_velocity = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [mhnt_pkg::COUNT_W-1:0]    out_held_count;
  logic                            out_any_held;
  logic [mhnt_pkg::NOTE_W-1:0]     out_lowest_note;
  logic [mhnt_pkg::CHAN_OUT_W-1:0] out_lowest_channel;
  logic [mhnt_pkg::NOTE_W-1:0]     out_highest_note;
  logic [mhnt_pkg::CHAN_OUT_W-1:0] out_highest_channel;

  // Shadow of the block's state: one channel mask per note and the pair count.
  logic [mhnt_pkg::CHANNELS-1:0] held_map [mhnt_pkg::NOTES];
  logic [mhnt_pkg::COUNT_W-1:0]  held_pairs;

  summary_t expected_summaries [$];
  int       mismatch_count = 0;
  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;
  int       long_holds_asked = 0;
  int       long_holds_done = 0;
  int       hold_left = 0;

  midi_held_note_tracker dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_status_byte      (in_status_byte),
    .in_note_number      (in_note_number),
    .in_velocity         (in_velocity),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_held_count      (out_held_count),
    .out_any_held        (out_any_held),
    .out_lowest_note     (out_lowest_note),
    .out_lowest_channel  (out_lowest_channel),
    .out_highest_note    (out_highest_note),
    .out_highest_channel (out_highest_channel)
  );

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  // Returns channel number 1..16 of the lowest set bit, 0 for an empty mask.
  function automatic logic [mhnt_pkg::CHAN_OUT_W-1:0] first_channel(
    input logic [mhnt_pkg::CHANNELS-1:0] mask
  );
    logic [mhnt_pkg::CHAN_OUT_W-1:0] chan;
    chan = '0;
    for (int c = mhnt_pkg::CHANNELS - 1; c >= 0; c--) begin
      if (mask[c]) chan = mhnt_pkg::CHAN_OUT_W'(c + 1);
    end
    return chan;
  endfunction

  function automatic summary_t apply_midi_beat(
    input logic [mhnt_pkg::STATUS_W-1:0] status,
    input logic [mhnt_pkg::NOTE_W-1:0]   note,
    input logic [mhnt_pkg::VEL_W-1:0]    vel
  );
    summary_t                s;
    logic [3:0]              kind;
    logic [3:0]              chan;
    logic                    was_held;
    logic                    found;
    kind = status[7:4];
    chan = status[3:0];
    if (kind == mhnt_pkg::KIND_NOTE_ON || kind == mhnt_pkg::KIND_NOTE_OFF) begin
      was_held = held_map[note][chan];
      if (kind == mhnt_pkg::KIND_NOTE_ON && vel != '0) begin
        if (!was_held) begin
          held_map[note][chan] = 1'b1;
          held_pairs = held_pairs + mhnt_pkg::COUNT_W'(1);
        end
      end else if (was_held) begin
        held_map[note][chan] = 1'b0;
        held_pairs = held_pairs - mhnt_pkg::COUNT_W'(1);
      end
    end
    s = NOTHING;
    s.count = held_pairs;
    s.any_held = (held_pairs != '0);
    found = 1'b0;
    for (int n = 0; n < mhnt_pkg::NOTES; n++) begin
      if (!found && held_map[n] != '0) begin
        found = 1'b1;
        s.low_note = mhnt_pkg::NOTE_W'(n);
        s.low_chan = first_channel(held_map[n]);
      end
    end
    found = 1'b0;
    for (int n = mhnt_pkg::NOTES - 1; n >= 0; n--) begin
      if (!found && held_map[n] != '0) begin
        found = 1'b1;
        s.high_note = mhnt_pkg::NOTE_W'(n);
        s.high_chan = first_channel(held_map[n]);
      end
    end
    return s;
  endfunction

  // Offers one beat and returns at the falling edge just before the accepting edge.
  task automatic send_beat(
    input logic [mhnt_pkg::STATUS_W-1:0] status,
    input logic [mhnt_pkg::NOTE_W-1:0]   note,
    input logic [mhnt_pkg::VEL_W-1:0]    vel,
    input logic                          typed,
    input summary_t                      want
  );
    summary_t predicted;
    @(posedge clk);
    in_valid       <= 1'b1;
    in_status_byte <= status;
    in_note_number <= note;
    in_velocity    <= vel;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    predicted = apply_midi_beat(status, note, vel);
    expected_summaries.push_back(typed ? want : predicted);
  endtask

  task automatic random_beat();
    int                            pick;
    logic [3:0]                    chan;
    logic [mhnt_pkg::STATUS_W-1:0] status;
    logic [mhnt_pkg::NOTE_W-1:0]   note;
    logic [mhnt_pkg::VEL_W-1:0]    vel;
    pick = $urandom_range(0, 99);
    chan = 4'($urandom_range(0, 15));
    // A narrow note pool makes releases and repeats land on held pairs.
    note = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(56, 63)) : 7'($urandom);
    if (pick < 55) begin
      status = {mhnt_pkg::KIND_NOTE_ON, chan};
      vel = 7'($urandom_range(1, 127));
    end else if (pick < 75) begin
      status = {mhnt_pkg::KIND_NOTE_OFF, chan};
      vel = 7'($urandom);
    end else if (pick < 85) begin
      status = {mhnt_pkg::KIND_NOTE_ON, chan};
      vel = '0;
    end else begin
      status = 8'($urandom);
      vel = 7'($urandom);
    end
    send_beat(status, note, vel, 1'b0, NOTHING);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      repeat ($urandom_range(1, 4)) begin
        @(posedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    @(posedge clk);
    in_valid <= 1'b0;
    while (expected_summaries.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (expected_summaries.size() != 0) begin
      mismatch_count++;
      $display("drain stuck with %0d results outstanding", expected_summaries.size());
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (long_holds_done != long_holds_asked) begin
      long_holds_done = long_holds_done + 1;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Inputs settle after the rising edge, so the handshake is stable here.
  always @(negedge clk) begin
    summary_t got;
    summary_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_held_count, out_any_held, out_lowest_note, out_lowest_channel,
              out_highest_note, out_highest_channel};
      if (expected_summaries.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: count=%0d", out_held_count);
      end else begin
        want = expected_summaries.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch exp: count=%0d any=%0d low=%0d/ch%0d high=%0d/ch%0d",
                     want.count, want.any_held, want.low_note, want.low_chan,
                     want.high_note, want.high_chan);
            $display("         got: count=%0d any=%0d low=%0d/ch%0d high=%0d/ch%0d",
                     got.count, got.any_held, got.low_note, got.low_chan,
                     got.high_note, got.high_chan);
          end
        end
      end
    end
  end

  initial begin
    foreach (held_map[n]) held_map[n] = '0;
    held_pairs = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      send_beat(DIRECTED_ROWS[i].status, DIRECTED_ROWS[i].note, DIRECTED_ROWS[i].vel,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 48;
          receiver_stall_pct = 0;
        end
        2: begin
          // The sender keeps offering through the hold-off, so the block
          // fills up and has to stall its input.
          sender_idle_pct = 0;
          receiver_stall_pct = 48;
          long_holds_asked++;
        end
        default: begin
          sender_idle_pct = 27;
          receiver_stall_pct = 27;
        end
      endcase
      repeat (PHASE_BEATS) random_beat();
      drain_results();
    end

    repeat (12) @(posedge clk);
    if (expected_summaries.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
